// ----- rtl/mtm_pkg.sv -----
// Shared constants, types and lookup functions for the MUS to MIDI transcoder.
`default_nettype none

package mtm_pkg;

  localparam int DELAY_BITS = 32;
  localparam int VLQ_GROUPS = (DELAY_BITS + 6) / 7;
  localparam int VLQ_PAD    = VLQ_GROUPS * 7;
  localparam int VLQ_CW     = $clog2(VLQ_GROUPS + 1);
  localparam int TAIL_LEN   = 7;
  localparam int TAIL_CW    = $clog2(TAIL_LEN + 1);

  localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_BEND     = 3'd2;
  localparam logic [2:0] KIND_SYSTEM   = 3'd3;
  localparam logic [2:0] KIND_CONTROL  = 3'd4;
  localparam logic [2:0] KIND_FINISH   = 3'd6;

  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROG     = 4'hC;
  localparam logic [3:0] ST_BEND     = 4'hE;

  localparam logic [7:0] META_MARK = 8'hFF;
  localparam logic [7:0] META_EOT  = 8'h2F;
  localparam logic [7:0] META_LEN  = 8'h00;

  localparam logic [4:0] SKIP_CHANNEL = 5'd9;
  localparam logic [3:0] PERC_SCORE   = 4'd15;
  localparam logic [3:0] PERC_MIDI    = 4'd9;
  localparam logic [6:0] VOL_RESET    = 7'd127;
  localparam logic [6:0] CTL_LIMIT    = 7'd10;

  typedef enum logic [3:0] {
    PH_DESC  = 4'b0001,
    PH_DATA1 = 4'b0010,
    PH_DATA2 = 4'b0100,
    PH_DELAY = 4'b1000
  } phase_t;

  typedef logic [7:0] byte_t;

  function automatic logic [6:0] ctl_number(input logic [3:0] c);
    logic [6:0] r;
    case (c)
      4'd1:    r = 7'd0;
      4'd2:    r = 7'd1;
      4'd3:    r = 7'd7;
      4'd4:    r = 7'd10;
      4'd5:    r = 7'd11;
      4'd6:    r = 7'd91;
      4'd7:    r = 7'd93;
      4'd8:    r = 7'd64;
      4'd9:    r = 7'd67;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] sys_controller(input logic [6:0] s);
    logic [6:0] r;
    case (s)
      7'd10:   r = 7'd120;
      7'd11:   r = 7'd123;
      7'd14:   r = 7'd121;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mtm_in_if.sv -----
// Score byte channel: valid/ready handshake with byte and last flag.
`default_nettype none

interface mtm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] score_byte;
  logic       score_last;

  modport source (output valid, output score_byte, output score_last, input ready);
  modport sink (input valid, input score_byte, input score_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/mtm_out_if.sv -----
// MIDI byte channel: valid/ready handshake with byte and run markers.
`default_nettype none

interface mtm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;
  logic       run_last;
  logic       track_done;

  modport source (output valid, output midi_byte, output run_last, output track_done,
                  input ready);
  modport sink (input valid, input midi_byte, input run_last, input track_done,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/mus_to_midi_event_transcoder.sv -----
// MUS score to MIDI track-body transcoder: parser, channel map and byte serializer.
// Latency: the first MIDI byte of an item is valid the cycle after the item is taken.
// Throughput: one MIDI byte per cycle while out_chan.ready is high; an item yields 0 to 12 bytes.
// An item with no bytes leaves the input ready for the next; otherwise the next item is taken on the last byte.
// Reset (rst_n low, synchronous): parser to descriptor phase, channel 15 mapped to 9,
// all volumes 127, delays cleared; no clearing pass is needed.
`default_nettype none

module mus_to_midi_event_transcoder
  import mtm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  mtm_in_if.sink     in_chan,
  mtm_out_if.source  out_chan
);

  phase_t                phase_r, phase_nxt;
  logic [2:0]            kind_r, kind_nxt;
  logic [3:0]            sch_r, sch_nxt;
  logic                  follows_r, follows_nxt;
  logic [7:0]            first_r, first_nxt;
  logic [3:0]            map_r [16];
  logic [15:0]           mapped_r;
  logic [6:0]            vol_r [16];
  logic [4:0]            nfree_r, nfree_nxt;
  logic [DELAY_BITS-1:0] pend_r, pend_nxt;
  logic [DELAY_BITS-1:0] gath_r, gath_nxt;
  logic                  finished_r, finished_nxt;

  logic [VLQ_PAD-1:0]    vlq_val_r;
  logic [VLQ_CW-1:0]     vlq_left_r;
  byte_t                 tail_r [TAIL_LEN];
  logic [TAIL_CW-1:0]    tail_left_r;
  logic                  done_r;

  logic                  map_we;
  logic [3:0]            map_idx;
  logic [3:0]            map_val;
  logic                  vol_we;
  logic [6:0]            vol_val;

  logic                  msg;
  logic                  len3;
  byte_t                 m0, m1, m2;
  logic                  fin;
  logic                  emit;
  logic [DELAY_BITS-1:0] pend_sum;
  logic [DELAY_BITS-1:0] gshift;
  logic [6:0]            sys_c;
  logic [6:0]            ctl_c;
  logic [4:0]            nf_use;

  byte_t                 tail_v [TAIL_LEN];
  logic [TAIL_CW-1:0]    tail_n;
  logic [VLQ_PAD-1:0]    vlq_pad;
  logic [VLQ_CW-1:0]     vlq_n;

  logic                  in_fire;
  logic                  busy;
  logic                  out_fire;
  logic                  run_last;
  logic [VLQ_CW-1:0]     vlq_idx;
  logic [6:0]            grp;

  logic [3:0]            ch;
  byte_t                 b;

  assign b        = in_chan.score_byte;
  assign ch       = map_r[sch_r];
  assign busy     = (vlq_left_r != '0) || (tail_left_r != '0);
  assign run_last = (vlq_left_r == '0) && (tail_left_r == TAIL_CW'(1));
  assign out_fire = out_chan.valid && out_chan.ready;
  assign in_chan.ready = !busy || (out_fire && run_last);
  assign in_fire  = in_chan.valid && in_chan.ready;

  // parse one score byte
  always_comb begin
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    sch_nxt      = sch_r;
    follows_nxt  = follows_r;
    first_nxt    = first_r;
    nfree_nxt    = nfree_r;
    gath_nxt     = gath_r;
    pend_sum     = pend_r;
    map_we       = 1'b0;
    map_idx      = b[3:0];
    map_val      = 4'd0;
    vol_we       = 1'b0;
    vol_val      = b[6:0];
    msg          = 1'b0;
    len3         = 1'b1;
    m0           = '0;
    m1           = '0;
    m2           = '0;
    fin          = 1'b0;
    sys_c        = sys_controller(b[6:0]);
    ctl_c        = ctl_number(first_r[3:0]);
    gshift       = DELAY_BITS'({gath_r, b[6:0]});
    nf_use       = (nfree_r == SKIP_CHANNEL) ? nfree_r + 5'd1 : nfree_r;

    if (in_fire && !finished_r) begin
      case (phase_r)
        PH_DESC: begin
          follows_nxt = b[7];
          kind_nxt    = b[6:4];
          sch_nxt     = b[3:0];
          if (b[6:4] == KIND_FINISH) begin
            fin = 1'b1;
          end else begin
            if (!mapped_r[b[3:0]]) begin
              map_we    = 1'b1;
              map_val   = nf_use[3:0];
              nfree_nxt = nf_use + 5'd1;
            end
            if (b[6:4] <= KIND_CONTROL) begin
              phase_nxt = PH_DATA1;
            end else if (b[7]) begin
              phase_nxt = PH_DELAY;
              gath_nxt  = '0;
            end else begin
              phase_nxt = PH_DESC;
            end
          end
        end
        PH_DATA1: begin
          first_nxt = b;
          if (kind_r == KIND_NOTE_OFF) begin
            msg = 1'b1;
            m0  = {ST_NOTE_OFF, ch};
            m1  = {1'b0, b[6:0]};
          end else if (kind_r == KIND_NOTE_ON) begin
            if (!b[7]) begin
              msg = 1'b1;
              m0  = {ST_NOTE_ON, ch};
              m1  = {1'b0, b[6:0]};
              m2  = {1'b0, vol_r[sch_r]};
            end
          end else if (kind_r == KIND_BEND) begin
            msg = 1'b1;
            m0  = {ST_BEND, ch};
            m1  = {1'b0, b[0], 6'd0};
            m2  = {1'b0, b[7:1]};
          end else if (kind_r == KIND_SYSTEM) begin
            if (sys_c != 7'd0) begin
              msg = 1'b1;
              m0  = {ST_CTRL, ch};
              m1  = {1'b0, sys_c};
            end
          end
          if ((kind_r == KIND_CONTROL) || ((kind_r == KIND_NOTE_ON) && b[7])) begin
            phase_nxt = PH_DATA2;
          end else if (follows_r) begin
            phase_nxt = PH_DELAY;
            gath_nxt  = '0;
          end else begin
            phase_nxt = PH_DESC;
          end
        end
        PH_DATA2: begin
          if (kind_r == KIND_NOTE_ON) begin
            vol_we = 1'b1;
            msg    = 1'b1;
            m0     = {ST_NOTE_ON, ch};
            m1     = {1'b0, first_r[6:0]};
            m2     = {1'b0, b[6:0]};
          end else if (first_r[6:0] == 7'd0) begin
            msg  = 1'b1;
            len3 = 1'b0;
            m0   = {ST_PROG, ch};
            m1   = {1'b0, b[6:0]};
          end else if (first_r[6:0] < CTL_LIMIT) begin
            msg = 1'b1;
            m0  = {ST_CTRL, ch};
            m1  = {1'b0, ctl_c};
            m2  = {1'b0, b[6:0]};
          end
          if (follows_r) begin
            phase_nxt = PH_DELAY;
            gath_nxt  = '0;
          end else begin
            phase_nxt = PH_DESC;
          end
        end
        PH_DELAY: begin
          if (b[7]) begin
            gath_nxt = gshift;
          end else begin
            pend_sum  = pend_r + gshift;
            gath_nxt  = '0;
            phase_nxt = PH_DESC;
          end
        end
        default: begin
          phase_nxt = PH_DESC;
        end
      endcase
      if (in_chan.score_last) begin
        fin = 1'b1;
      end
    end

    emit         = msg || fin;
    pend_nxt     = emit ? '0 : pend_sum;
    finished_nxt = finished_r || fin;
  end

  // build the byte run: delay quantity, then message and end-of-track bytes
  always_comb begin
    for (int i = 0; i < TAIL_LEN; i++) begin
      tail_v[i] = '0;
    end
    tail_n = TAIL_CW'(3);
    if (msg) begin
      tail_v[0] = m0;
      tail_v[1] = m1;
      if (len3) begin
        tail_v[2] = m2;
        if (fin) begin
          tail_v[3] = META_LEN;
          tail_v[4] = META_MARK;
          tail_v[5] = META_EOT;
          tail_v[6] = META_LEN;
        end
        tail_n = fin ? TAIL_CW'(7) : TAIL_CW'(3);
      end else begin
        if (fin) begin
          tail_v[2] = META_LEN;
          tail_v[3] = META_MARK;
          tail_v[4] = META_EOT;
          tail_v[5] = META_LEN;
        end
        tail_n = fin ? TAIL_CW'(6) : TAIL_CW'(2);
      end
    end else begin
      tail_v[0] = META_MARK;
      tail_v[1] = META_EOT;
      tail_v[2] = META_LEN;
    end

    vlq_pad = VLQ_PAD'(pend_sum);
    vlq_n   = VLQ_CW'(1);
    for (int g = 0; g < VLQ_GROUPS; g++) begin
      if (vlq_pad[g*7 +: 7] != 7'd0) begin
        vlq_n = VLQ_CW'(g + 1);
      end
    end
  end

  // select the current delay group
  always_comb begin
    vlq_idx = vlq_left_r - VLQ_CW'(1);
    grp     = '0;
    for (int g = 0; g < VLQ_GROUPS; g++) begin
      if (VLQ_CW'(g) == vlq_idx) begin
        grp = vlq_val_r[g*7 +: 7];
      end
    end
  end

  assign out_chan.valid      = busy;
  assign out_chan.midi_byte  = (vlq_left_r != '0) ? {(vlq_left_r > VLQ_CW'(1)), grp}
                                                   : tail_r[0];
  assign out_chan.run_last   = run_last;
  assign out_chan.track_done = done_r && run_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_DESC;
      kind_r     <= '0;
      sch_r      <= '0;
      follows_r  <= 1'b0;
      first_r    <= '0;
      mapped_r   <= 16'h8000;
      for (int i = 0; i < 16; i++) begin
        map_r[i] <= (i == int'(PERC_SCORE)) ? PERC_MIDI : 4'd0;
        vol_r[i] <= VOL_RESET;
      end
      nfree_r    <= '0;
      pend_r     <= '0;
      gath_r     <= '0;
      finished_r <= 1'b0;
      vlq_left_r <= '0;
      tail_left_r <= '0;
      done_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      kind_r     <= kind_nxt;
      sch_r      <= sch_nxt;
      follows_r  <= follows_nxt;
      first_r    <= first_nxt;
      nfree_r    <= nfree_nxt;
      pend_r     <= pend_nxt;
      gath_r     <= gath_nxt;
      finished_r <= finished_nxt;
      if (map_we) begin
        map_r[map_idx]    <= map_val;
        mapped_r[map_idx] <= 1'b1;
      end
      if (vol_we) begin
        vol_r[sch_r] <= vol_val;
      end
      if (emit) begin
        vlq_left_r  <= vlq_n;
        tail_left_r <= tail_n;
        done_r      <= fin;
      end else if (out_fire) begin
        if (vlq_left_r != '0) begin
          vlq_left_r <= vlq_left_r - VLQ_CW'(1);
        end else begin
          tail_left_r <= tail_left_r - TAIL_CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      vlq_val_r <= vlq_pad;
      for (int i = 0; i < TAIL_LEN; i++) begin
        tail_r[i] <= tail_v[i];
      end
    end else if (out_fire && (vlq_left_r == '0)) begin
      for (int i = 0; i < TAIL_LEN - 1; i++) begin
        tail_r[i] <= tail_r[i+1];
      end
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the MUS to MIDI transcoder: score byte stimulus, MIDI byte scoreboard.
module tb;
  import mtm_pkg::*;

  localparam int IDLE_PCT       = 29;
  localparam int RANDOM_ITEMS   = 215;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;

  localparam logic [4:0] UNMAPPED_CH = 5'h1F;
  localparam logic [2:0] KIND_SPARE5 = 3'd5;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  localparam logic [6:0] SYS_ALL_SOUND_OFF = 7'd10;
  localparam logic [6:0] SYS_ALL_NOTES_OFF = 7'd11;
  localparam logic [6:0] SYS_RESET_CTRLS   = 7'd14;
  localparam logic [6:0] CC_ALL_SOUND_OFF  = 7'd120;
  localparam logic [6:0] CC_ALL_NOTES_OFF  = 7'd123;
  localparam logic [6:0] CC_RESET_CTRLS    = 7'd121;

  localparam logic [6:0] CTL_TABLE [10] = '{0, 0, 1, 7, 10, 11, 91, 93, 64, 67};
  localparam logic [6:0] SYS_CODES [3]  = '{SYS_ALL_SOUND_OFF, SYS_ALL_NOTES_OFF,
                                            SYS_RESET_CTRLS};

  localparam int DIRECTED_LEN = 28;
  localparam byte_t DIRECTED [DIRECTED_LEN] = '{
    8'h00, 8'h7F,
    8'h9F, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
    8'hD3, 8'h7F,
    8'h11, 8'hC0, 8'h22,
    8'h11, 8'h31,
    8'h21, 8'hFF,
    8'h35, 8'h0A,
    8'h47, 8'h80, 8'h85,
    8'hC7, 8'h0A, 8'h55, 8'h01,
    8'h78
  };

  typedef struct packed {
    byte_t midi;
    logic  run_last;
    logic  track_done;
  } midi_item_t;

  class midi_scoreboard;
    midi_item_t            expected_midi[$];
    midi_item_t            step_out[$];
    phase_t                phase;
    logic [2:0]            kind;
    logic [3:0]            chan;
    logic                  follows;
    byte_t                 first_data;
    logic [4:0]            chan_map[16];
    logic [6:0]            chan_vol[16];
    logic [4:0]            next_free;
    logic [DELAY_BITS-1:0] pending;
    logic [DELAY_BITS-1:0] gather;
    bit                    finished;
    int                    errors;
    int                    score_seen;
    int                    midi_seen;
    int                    tracks_done;

    function new();
      phase = PH_DESC;
      kind = '0;
      chan = '0;
      follows = 1'b0;
      first_data = '0;
      for (int i = 0; i < 16; i++) begin
        chan_map[i] = UNMAPPED_CH;
        chan_vol[i] = VOL_RESET;
      end
      chan_map[PERC_SCORE] = {1'b0, PERC_MIDI};
      next_free = '0;
      pending = '0;
      gather = '0;
      finished = 1'b0;
      errors = 0;
      score_seen = 0;
      midi_seen = 0;
      tracks_done = 0;
    endfunction

    function void emit(byte_t b, logic done);
      midi_item_t m;
      m.midi = b;
      m.run_last = 1'b0;
      m.track_done = done;
      step_out.push_back(m);
    endfunction

    function void emit_delay();
      byte_t                 grp[5];
      int                    n;
      logic [DELAY_BITS-1:0] v;
      v = pending;
      grp[0] = {1'b0, v[6:0]};
      n = 1;
      v = v >> 7;
      while (v != '0 && n < 5) begin
        grp[n] = {1'b1, v[6:0]};
        n++;
        v = v >> 7;
      end
      for (int i = n - 1; i >= 0; i--) emit(grp[i], 1'b0);
    endfunction

    function void emit_msg(byte_t status, byte_t d1, byte_t d2, bit three);
      emit_delay();
      emit(status, 1'b0);
      emit(d1, 1'b0);
      if (three) emit(d2, 1'b0);
      pending = '0;
    endfunction

    function void end_track();
      emit_delay();
      emit(META_MARK, 1'b0);
      emit(META_EOT, 1'b0);
      emit(META_LEN, 1'b1);
      pending = '0;
      finished = 1'b1;
    endfunction

    function void close_event();
      if (follows) begin
        phase = PH_DELAY;
        gather = '0;
      end else begin
        phase = PH_DESC;
      end
    endfunction

    function void note_score_byte(byte_t b, logic last);
      logic [3:0] mch;
      logic [6:0] c;
      midi_item_t m;
      if (finished) return;
      score_seen++;
      step_out.delete();
      mch = chan_map[chan][3:0];
      case (phase)
        PH_DESC: begin
          follows = b[7];
          kind = b[6:4];
          chan = b[3:0];
          if (kind == KIND_FINISH) begin
            end_track();
          end else begin
            if (chan_map[chan] == UNMAPPED_CH) begin
              if (next_free == SKIP_CHANNEL) next_free++;
              chan_map[chan] = next_free;
              next_free++;
            end
            if (kind <= KIND_CONTROL) phase = PH_DATA1;
            else close_event();
          end
        end
        PH_DATA1: begin
          first_data = b;
          case (kind)
            KIND_NOTE_OFF: begin
              emit_msg({ST_NOTE_OFF, mch}, {1'b0, b[6:0]}, 8'h00, 1'b1);
              close_event();
            end
            KIND_NOTE_ON: begin
              if (b[7]) begin
                phase = PH_DATA2;
              end else begin
                emit_msg({ST_NOTE_ON, mch}, {1'b0, b[6:0]}, {1'b0, chan_vol[chan]}, 1'b1);
                close_event();
              end
            end
            KIND_BEND: begin
              emit_msg({ST_BEND, mch}, {1'b0, b[0], 6'b0}, {1'b0, b[7:1]}, 1'b1);
              close_event();
            end
            KIND_SYSTEM: begin
              case (b[6:0])
                SYS_ALL_SOUND_OFF: c = CC_ALL_SOUND_OFF;
                SYS_ALL_NOTES_OFF: c = CC_ALL_NOTES_OFF;
                SYS_RESET_CTRLS:   c = CC_RESET_CTRLS;
                default:           c = '0;
              endcase
              if (c != '0) emit_msg({ST_CTRL, mch}, {1'b0, c}, 8'h00, 1'b1);
              close_event();
            end
            default: phase = PH_DATA2;
          endcase
        end
        PH_DATA2: begin
          if (kind == KIND_NOTE_ON) begin
            chan_vol[chan] = b[6:0];
            emit_msg({ST_NOTE_ON, mch}, {1'b0, first_data[6:0]}, {1'b0, b[6:0]}, 1'b1);
          end else begin
            c = first_data[6:0];
            if (c == '0)
              emit_msg({ST_PROG, mch}, {1'b0, b[6:0]}, 8'h00, 1'b0);
            else if (c < CTL_LIMIT)
              emit_msg({ST_CTRL, mch}, {1'b0, CTL_TABLE[c]}, {1'b0, b[6:0]}, 1'b1);
          end
          close_event();
        end
        default: begin
          gather = (gather << 7) | DELAY_BITS'(b[6:0]);
          if (!b[7]) begin
            pending = pending + gather;
            gather = '0;
            phase = PH_DESC;
          end
        end
      endcase
      if (last && !finished) end_track();
      if (step_out.size() > 0) begin
        m = step_out.pop_back();
        m.run_last = 1'b1;
        step_out.push_back(m);
      end
      foreach (step_out[i]) expected_midi.push_back(step_out[i]);
    endfunction

    function void check_midi(byte_t b, logic rl, logic td);
      midi_item_t e;
      midi_seen++;
      if (expected_midi.size() == 0) begin
        errors++;
        $error("unexpected MIDI item: midi_byte %h run_last %b track_done %b", b, rl, td);
        return;
      end
      e = expected_midi.pop_front();
      if (e.track_done) tracks_done++;
      if (b !== e.midi) begin
        errors++;
        $error("midi_byte: expected %h, actual %h", e.midi, b);
      end
      if (rl !== e.run_last) begin
        errors++;
        $error("run_last: expected %b, actual %b", e.run_last, rl);
      end
      if (td !== e.track_done) begin
        errors++;
        $error("track_done: expected %b, actual %b", e.track_done, td);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct;
  int   stall_cycles;

  midi_scoreboard sb;

  mtm_in_if  in_ch();
  mtm_out_if out_ch();

  mus_to_midi_event_transcoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_midi(out_ch.midi_byte, out_ch.run_last, out_ch.track_done);
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_byte(input byte_t b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.score_byte <= b;
    in_ch.score_last <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_score_byte(b, last);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_midi.size() != 0);
  endtask

  // complete any open event part with bytes that carry no continuation bit
  task automatic resync();
    while (sb.phase != PH_DESC) send_byte(8'($urandom_range(0, 127)), 1'b0);
  endtask

  task automatic send_noise();
    byte_t b;
    b = 8'($urandom_range(0, 255));
    if (sb.phase == PH_DESC && b[6:4] == KIND_FINISH) b[6:4] = KIND_SPARE7;
    send_byte(b, 1'b0);
  endtask

  task automatic send_delay();
    int groups;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) groups = 1;
    else if (r < 85) groups = 2;
    else if (r < 95) groups = 3;
    else groups = $urandom_range(4, 6);
    repeat (groups - 1) send_byte({1'b1, 7'($urandom_range(0, 127))}, 1'b0);
    send_byte({1'b0, 7'($urandom_range(0, 127))}, 1'b0);
  endtask

  task automatic send_random_event();
    int         r;
    logic [2:0] kind;
    byte_t      d;
    r = $urandom_range(0, 99);
    if (r < 20) kind = KIND_NOTE_OFF;
    else if (r < 45) kind = KIND_NOTE_ON;
    else if (r < 55) kind = KIND_BEND;
    else if (r < 67) kind = KIND_SYSTEM;
    else if (r < 85) kind = KIND_CONTROL;
    else if (r < 92) kind = KIND_SPARE5;
    else kind = KIND_SPARE7;
    send_byte({1'($urandom_range(0, 1)), kind, 4'($urandom_range(0, 15))}, 1'b0);
    case (kind)
      KIND_NOTE_OFF, KIND_BEND: begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      KIND_NOTE_ON: begin
        d = 8'($urandom_range(0, 255));
        send_byte(d, 1'b0);
        if (d[7]) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      KIND_SYSTEM: begin
        if ($urandom_range(0, 99) < 75)
          d = {1'($urandom_range(0, 1)), SYS_CODES[$urandom_range(0, 2)]};
        else
          d = 8'($urandom_range(0, 255));
        send_byte(d, 1'b0);
      end
      KIND_CONTROL: begin
        if ($urandom_range(0, 99) < 80)
          d = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 9))};
        else
          d = {1'($urandom_range(0, 1)), 7'($urandom_range(10, 127))};
        send_byte(d, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      default: ;
    endcase
    if (sb.phase == PH_DELAY) send_delay();
  endtask

  // end the score one of three ways, then feed bytes that must be ignored
  task automatic finish_score();
    resync();
    case ($urandom_range(0, 2))
      0: send_byte({1'($urandom_range(0, 1)), KIND_FINISH, 4'($urandom_range(0, 15))},
                   1'($urandom_range(0, 1)));
      1: begin
        send_byte({1'($urandom_range(0, 1)), KIND_NOTE_OFF, 4'($urandom_range(0, 15))}, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      default: send_byte({1'($urandom_range(0, 1)), KIND_NOTE_ON,
                          4'($urandom_range(0, 15))}, 1'b1);
    endcase
    repeat (4) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    idle_pct = IDLE_PCT;
    stall_cycles = 0;
    in_ch.valid = 1'b0;
    in_ch.score_byte = '0;
    in_ch.score_last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i], 1'b0);
    drain_results();

    while (sb.score_seen < DIRECTED_LEN + RANDOM_ITEMS) begin
      if (sb.score_seen > DIRECTED_LEN + 90 && sb.score_seen < DIRECTED_LEN + 160)
        idle_pct = 0;
      else
        idle_pct = IDLE_PCT;
      if ($urandom_range(0, 99) < 12) begin
        send_noise();
      end else begin
        resync();
        send_random_event();
      end
      if ($urandom_range(0, 99) < 2) drain_results();
    end
    idle_pct = IDLE_PCT;
    finish_score();
    in_ch.valid <= 1'b0;

    while (sb.expected_midi.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d score bytes of every event kind, including delay wrap and an",
             sb.score_seen);
    $display("end-of-score case; %0d MIDI bytes checked, %0d end-of-track marker seen.",
             sb.midi_seen, sb.tracks_done);
    if (sb.errors == 0 && sb.expected_midi.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/mtm_pkg.sv
rtl/mtm_in_if.sv
rtl/mtm_out_if.sv
rtl/mus_to_midi_event_transcoder.sv
bench/tb.sv
